@@ src/gstr_pkg.sv @@
// Shared constants for the Gardner symbol timing recovery block.
package gstr_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned MAX_SPS_DEF      = 80;

  localparam int unsigned SPS_CFG_W  = 7;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned OFS_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS  = 2'd2;

  localparam logic [SPS_CFG_W-1:0] SPS_RST  = 7'd60;
  localparam logic [GAIN_W-1:0]    GAIN_RST = 16'd655;
  localparam logic [OFS_W-1:0]     OFS_RST  = 12'd0;

  localparam int unsigned MU_W       = 16;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned FRAC_SHIFT = 15;
  localparam int unsigned MU_ONE     = 32768;
  localparam int unsigned MU_HALF    = 16384;
  localparam int unsigned MIN_SPS    = 2;

  localparam int unsigned      ERR_W     = 47;
  localparam logic [63:0]      ERR_LIMIT = 64'd70368744177663;

endpackage

@@ src/gstr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gstr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gstr_mul.sv @@
// Shared signed multiplier with registered product.
module gstr_mul #(
  parameter int unsigned A_W = 47,
  parameter int unsigned B_W = 17
) (
  input  logic                     clk_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic signed [B_W-1:0]    b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ src/gardner_symbol_timing_recovery.sv @@
// Gardner symbol timing recovery: history RAM, shared multiplier and sequencer.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata {sample_q, sample_i}, tuser burst_start
//  m_axis   | out | m_axis_tvalid/tready   | tdata {timing_phase, symbol_q, symbol_i},
//           |     |                        | tuser first_of_burst
//  cfg      | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A sample that is no symbol strobe is only accepted. A strobe sample is accepted, then
// 4 history RAM reads go through its single read port, 9 sequencer steps run around the
// shared multiplier and the output register is loaded (waiting while m_axis stalls); no
// new sample is taken until then. Burst start clears the history through a fill count;
// no clearing pass. Reset is asynchronous, active low, and returns the control and
// configuration registers to their defaults.
module gardner_symbol_timing_recovery #(
  parameter int unsigned MAX_SPS      = gstr_pkg::MAX_SPS_DEF,
  parameter int unsigned SAMPLE_WIDTH = gstr_pkg::SAMPLE_WIDTH_DEF,
  localparam int unsigned IN_DW  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((2 * SAMPLE_WIDTH + gstr_pkg::MU_W + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // {sample_i, sample_q} from bit 0 up
  input  logic [IN_DW-1:0]                   s_axis_tdata,
  // burst_start
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // {symbol_i, symbol_q, timing_phase} from bit 0 up
  output logic [OUT_DW-1:0]                  m_axis_tdata,
  // first_of_burst
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we_i,
  input  logic [gstr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gstr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SW         = SAMPLE_WIDTH;
  localparam int unsigned MU_W       = gstr_pkg::MU_W;
  localparam int unsigned FRAC_W     = gstr_pkg::FRAC_W;
  localparam int unsigned HIST_DEPTH = MAX_SPS / 2 + 3;
  localparam int unsigned AGE_W      = $clog2(HIST_DEPTH);
  localparam int unsigned RAM_DEPTH  = 1 << AGE_W;
  localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int unsigned SPS_W      = $clog2(MAX_SPS + 1);
  localparam int unsigned CMP_W      = (SPS_W > gstr_pkg::SPS_CFG_W) ? SPS_W
                                                                      : gstr_pkg::SPS_CFG_W;
  localparam int unsigned MA_W       = gstr_pkg::ERR_W;
  localparam int unsigned MB_W       = (SW > FRAC_W) ? SW : FRAC_W;
  localparam int unsigned P_W        = MA_W + MB_W;
  localparam int unsigned ACC_W      = (2 * SW + 2 > gstr_pkg::ERR_W + 1) ? 2 * SW + 2
                                                                          : gstr_pkg::ERR_W + 1;
  localparam int unsigned DSH        = 2 * SW - 3;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;

  localparam logic [3:0] FETCH_LAST = 4'd4;
  localparam logic [3:0] CALC_LAST  = 4'd8;

  localparam logic signed [P_W-1:0]   LERP_HALF = P_W'(1) << (gstr_pkg::FRAC_SHIFT - 1);
  localparam logic signed [P_W-1:0]   D_HALF    = P_W'(1) << (DSH - 1);
  localparam logic signed [P_W-1:0]   MU_HI     = P_W'(gstr_pkg::MU_HALF);
  localparam logic signed [P_W-1:0]   MU_LO     = -MU_HI;
  localparam logic signed [ACC_W-1:0] ERR_HI    = ACC_W'(gstr_pkg::ERR_LIMIT);
  localparam logic signed [ACC_W-1:0] ERR_LO    = -ERR_HI;
  localparam logic signed [FRAC_W-1:0] FRAC_ONE = FRAC_W'(gstr_pkg::MU_ONE);

  logic [gstr_pkg::SPS_CFG_W-1:0] cfg_sps_q;
  logic [gstr_pkg::GAIN_W-1:0]    cfg_gain_q;
  logic [gstr_pkg::OFS_W-1:0]     cfg_ofs_q;

  logic [2:0]                 state_q, state_d;
  logic [3:0]                 step_q, step_d;
  logic [gstr_pkg::OFS_W-1:0] cnt_q;
  logic [AGE_W-1:0]           wr_ptr_q;
  logic [FILL_W-1:0]          fill_q;
  logic signed [MU_W-1:0]     mu_q;
  logic                       have_prev_q;
  logic                       rd_ok_q;

  logic [1:0]                 p_q;
  logic [AGE_W-1:0]           m_q;
  logic signed [FRAC_W-1:0]   frac_q;

  logic signed [SW-1:0]       hold_i_q [4];
  logic signed [SW-1:0]       hold_q_q [4];
  logic signed [SW-1:0]       sym_i_q, sym_q_q, mid_i_q, mid_q_q;
  logic signed [SW-1:0]       prev_i_q, prev_q_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [MU_W-1:0]     mu_upd_q;

  logic                       out_valid_q;
  logic signed [SW-1:0]       out_i_q, out_q_q;
  logic signed [MU_W-1:0]     out_mu_q;
  logic                       out_first_q;

  logic                       in_fire;
  logic                       emit_go;
  logic [AGE_W-1:0]           wr_addr;
  logic [AGE_W-1:0]           age_sel;
  logic [AGE_W-1:0]           rd_addr;
  logic [2*SW-1:0]            rd_data;
  logic [1:0]                 hold_idx;
  logic [CMP_W-1:0]           sps_raw, sps_eff;

  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [P_W-1:0]      mul_p;

  logic signed [SW:0]         diff;
  logic signed [SW-1:0]       lerp_base;
  logic signed [P_W-1:0]      lerp_sum, lerp_off;
  logic signed [SW-1:0]       lerp_res;
  logic signed [ACC_W-1:0]    err_sat;
  logic signed [P_W-1:0]      d_sum, delta, mu_wide;
  logic signed [MU_W-1:0]     mu_clamp;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign emit_go       = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign wr_addr       = wr_ptr_q + AGE_W'(1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sps_q  <= gstr_pkg::SPS_RST;
      cfg_gain_q <= gstr_pkg::GAIN_RST;
      cfg_ofs_q  <= gstr_pkg::OFS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gstr_pkg::CFG_SPS:  cfg_sps_q  <= cfg_data_i[gstr_pkg::SPS_CFG_W-1:0];
        gstr_pkg::CFG_GAIN: cfg_gain_q <= cfg_data_i[gstr_pkg::GAIN_W-1:0];
        gstr_pkg::CFG_OFS:  cfg_ofs_q  <= cfg_data_i[gstr_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the strobe interval
  always_comb begin
    sps_raw = CMP_W'(cfg_sps_q);
    sps_eff = sps_raw;
    if (sps_raw < CMP_W'(gstr_pkg::MIN_SPS)) begin
      sps_eff = CMP_W'(gstr_pkg::MIN_SPS);
    end else if (sps_raw > CMP_W'(MAX_SPS)) begin
      sps_eff = CMP_W'(MAX_SPS);
    end
  end

  gstr_ram #(
    .WIDTH(2 * SW),
    .DEPTH(RAM_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (in_fire),
    .waddr_i(wr_addr),
    .wdata_i(s_axis_tdata[2*SW-1:0]),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Read ages: strobe pair, then midpoint pair
  always_comb begin
    unique case (step_q[1:0])
      2'd0:    age_sel = AGE_W'(p_q);
      2'd1:    age_sel = AGE_W'(p_q) - AGE_W'(1);
      2'd2:    age_sel = m_q;
      default: age_sel = m_q - AGE_W'(1);
    endcase
  end
  assign rd_addr  = wr_ptr_q - age_sel;
  assign hold_idx = step_q[1:0] - 2'd1;

  gstr_mul #(
    .A_W(MA_W),
    .B_W(MB_W)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // Operand select for the shared multiplier
  always_comb begin
    diff  = '0;
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      4'd0: begin
        diff  = (SW+1)'(hold_i_q[1]) - (SW+1)'(hold_i_q[0]);
        mul_a = MA_W'(diff);
        mul_b = MB_W'(frac_q);
      end
      4'd1: begin
        diff  = (SW+1)'(hold_q_q[1]) - (SW+1)'(hold_q_q[0]);
        mul_a = MA_W'(diff);
        mul_b = MB_W'(frac_q);
      end
      4'd2: begin
        diff  = (SW+1)'(hold_i_q[3]) - (SW+1)'(hold_i_q[2]);
        mul_a = MA_W'(diff);
        mul_b = MB_W'(frac_q);
      end
      4'd3: begin
        diff  = (SW+1)'(hold_q_q[3]) - (SW+1)'(hold_q_q[2]);
        mul_a = MA_W'(diff);
        mul_b = MB_W'(frac_q);
      end
      4'd4: begin
        diff  = (SW+1)'(sym_i_q) - (SW+1)'(prev_i_q);
        mul_a = MA_W'(diff);
        mul_b = MB_W'(mid_i_q);
      end
      4'd5: begin
        diff  = (SW+1)'(sym_q_q) - (SW+1)'(prev_q_q);
        mul_a = MA_W'(diff);
        mul_b = MB_W'(mid_q_q);
      end
      4'd7: begin
        mul_a = err_sat[MA_W-1:0];
        mul_b = MB_W'($signed({1'b0, cfg_gain_q}));
      end
      default: ;
    endcase
  end

  // Interpolation rounding
  always_comb begin
    unique case (step_q)
      4'd1:    lerp_base = hold_i_q[0];
      4'd2:    lerp_base = hold_q_q[0];
      4'd3:    lerp_base = hold_i_q[2];
      default: lerp_base = hold_q_q[2];
    endcase
    lerp_sum = mul_p + LERP_HALF;
    lerp_off = lerp_sum >>> gstr_pkg::FRAC_SHIFT;
    lerp_res = lerp_base + $signed(lerp_off[SW-1:0]);
  end

  // Error saturation and phase update
  always_comb begin
    err_sat = acc_q;
    if (acc_q > ERR_HI) begin
      err_sat = ERR_HI;
    end else if (acc_q < ERR_LO) begin
      err_sat = ERR_LO;
    end
    d_sum   = mul_p + D_HALF;
    delta   = d_sum >>> DSH;
    mu_wide = P_W'(mu_q) - delta;
    if (mu_wide > MU_HI) begin
      mu_clamp = MU_W'(MU_HI);
    end else if (mu_wide < MU_LO) begin
      mu_clamp = MU_W'(MU_LO);
    end else begin
      mu_clamp = mu_wide[MU_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_fire && !s_axis_tuser && (cnt_q == '0)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (step_q == FETCH_LAST) begin
          state_d = ST_CALC;
          step_d  = '0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_CALC: begin
        if (step_q == CALC_LAST) begin
          state_d = ST_EMIT;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      mu_q        <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_fire) begin
        wr_ptr_q <= wr_addr;
        if (s_axis_tuser) begin
          fill_q      <= FILL_W'(1);
          mu_q        <= '0;
          have_prev_q <= 1'b0;
          cnt_q       <= cfg_ofs_q;
        end else begin
          if (fill_q < FILL_W'(HIST_DEPTH)) begin
            fill_q <= fill_q + FILL_W'(1);
          end
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - gstr_pkg::OFS_W'(1);
          end else begin
            cnt_q <= gstr_pkg::OFS_W'(sps_eff - CMP_W'(1));
          end
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
        have_prev_q <= 1'b1;
        if (have_prev_q) begin
          mu_q <= mu_upd_q;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p_q <= mu_q[MU_W-1] ? 2'd2 : 2'd1;
      m_q <= AGE_W'(mu_q[MU_W-1] ? 2'd2 : 2'd1) + AGE_W'(sps_eff >> 1);
      if (mu_q[MU_W-1]) begin
        frac_q <= FRAC_W'(mu_q) + FRAC_ONE;
      end else begin
        frac_q <= FRAC_W'(mu_q);
      end
    end
    if (state_q == ST_FETCH) begin
      rd_ok_q <= (FILL_W'(age_sel) < fill_q);
      if (step_q != '0) begin
        hold_i_q[hold_idx] <= rd_ok_q ? $signed(rd_data[SW-1:0]) : '0;
        hold_q_q[hold_idx] <= rd_ok_q ? $signed(rd_data[2*SW-1:SW]) : '0;
      end
    end
    if (state_q == ST_CALC) begin
      unique case (step_q)
        4'd1: sym_i_q  <= lerp_res;
        4'd2: sym_q_q  <= lerp_res;
        4'd3: mid_i_q  <= lerp_res;
        4'd4: mid_q_q  <= lerp_res;
        4'd5: acc_q    <= mul_p[ACC_W-1:0];
        4'd6: acc_q    <= acc_q + mul_p[ACC_W-1:0];
        4'd8: mu_upd_q <= mu_clamp;
        default: ;
      endcase
    end
    if (emit_go) begin
      out_i_q     <= sym_i_q;
      out_q_q     <= sym_q_q;
      out_mu_q    <= mu_q;
      out_first_q <= !have_prev_q;
      prev_i_q    <= sym_i_q;
      prev_q_q    <= sym_q_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DW'({out_mu_q, out_q_q, out_i_q});
  assign m_axis_tuser  = out_first_q;

endmodule

@@ sim/gardner_symbol_timing_recovery_tb.sv @@
// Self-checking testbench for the Gardner symbol timing recovery block.
module gardner_symbol_timing_recovery_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HistDepth = gstr_pkg::MAX_SPS_DEF / 2 + 3;
  localparam longint MuHalf    = gstr_pkg::MU_HALF;
  localparam longint MuOne     = gstr_pkg::MU_ONE;
  localparam longint ErrMax    = gstr_pkg::ERR_LIMIT;

  typedef struct {
    logic signed [15:0] si;
    logic signed [15:0] sq;
    bit                 start;
  } sample_t;

  typedef struct {
    logic signed [15:0] sym_i;
    logic signed [15:0] sym_q;
    logic signed [15:0] phase;
    logic               first;
  } symbol_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  sample_t pending_samples[$];
  symbol_t expected_symbols[$];
  sample_t offered;
  int      queued_cnt = 0;
  int      accepted_cnt = 0;
  int      errors = 0;
  bit      calm = 1'b0;
  bit      stall_req = 1'b0;
  bit      stall_done = 1'b0;
  int      stall_cnt = 0;

  logic signed [15:0] hist_i [0:HistDepth-1];
  logic signed [15:0] hist_q [0:HistDepth-1];
  logic [11:0]        skip_cnt = '0;
  logic signed [15:0] mu = '0;
  logic signed [15:0] last_i = '0;
  logic signed [15:0] last_q = '0;
  bit                 have_last = 1'b0;
  logic [6:0]         cur_sps = gstr_pkg::SPS_RST;
  logic [15:0]        cur_gain = gstr_pkg::GAIN_RST;
  logic [11:0]        cur_ofs = gstr_pkg::OFS_RST;

  gardner_symbol_timing_recovery dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint interp(longint y0, longint y1, longint frac);
    longint t;
    t = frac * (y1 - y0) + (longint'(1) << 14);
    return y0 + (t >>> 15);
  endfunction

  task automatic recover_symbol(input sample_t it, output bit emit, output symbol_t sym);
    int     sps;
    int     p;
    int     m;
    longint frac;
    longint yi;
    longint yq;
    longint mi;
    longint mq;
    longint err;
    longint mu_next;
    emit = 1'b0;
    sym = '{default: '0};
    if (it.start) begin
      for (int k = 0; k < HistDepth; k++) begin
        hist_i[k] = '0;
        hist_q[k] = '0;
      end
      mu = '0;
      have_last = 1'b0;
      skip_cnt = cur_ofs;
    end
    for (int k = HistDepth - 1; k > 0; k--) begin
      hist_i[k] = hist_i[k-1];
      hist_q[k] = hist_q[k-1];
    end
    hist_i[0] = it.si;
    hist_q[0] = it.sq;
    if (it.start) return;
    if (skip_cnt != 0) begin
      skip_cnt = skip_cnt - 1'b1;
      return;
    end
    sps = cur_sps;
    if (sps < gstr_pkg::MIN_SPS) sps = gstr_pkg::MIN_SPS;
    if (sps > gstr_pkg::MAX_SPS_DEF) sps = gstr_pkg::MAX_SPS_DEF;
    skip_cnt = 12'(sps - 1);
    if (mu >= 0) begin
      p = 1;
      frac = mu;
    end else begin
      p = 2;
      frac = longint'(mu) + MuOne;
    end
    m = p + sps / 2;
    yi = interp(hist_i[p], hist_i[p-1], frac);
    yq = interp(hist_q[p], hist_q[p-1], frac);
    mi = interp(hist_i[m], hist_i[m-1], frac);
    mq = interp(hist_q[m], hist_q[m-1], frac);
    sym.sym_i = 16'(yi);
    sym.sym_q = 16'(yq);
    sym.phase = mu;
    sym.first = !have_last;
    if (have_last) begin
      err = mi * (yi - longint'(last_i)) + mq * (yq - longint'(last_q));
      if (err > ErrMax) err = ErrMax;
      if (err < -ErrMax) err = -ErrMax;
      mu_next = longint'(mu) -
                ((longint'(cur_gain) * err + (longint'(1) << 28)) >>> 29);
      if (mu_next > MuHalf) mu_next = MuHalf;
      if (mu_next < -MuHalf) mu_next = -MuHalf;
      mu = 16'(mu_next);
    end
    last_i = sym.sym_i;
    last_q = sym.sym_q;
    have_last = 1'b1;
    emit = 1'b1;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    bit      emit;
    symbol_t sym;
    if (s_axis_tvalid && s_axis_tready) begin
      recover_symbol(offered, emit, sym);
      if (emit) expected_symbols.insert(expected_symbols.size(), sym);
      accepted_cnt++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
        offered = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {offered.sq, offered.si};
        s_axis_tuser <= offered.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    symbol_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_symbols.size() == 0) begin
        report_mismatch("unexpected symbol_i", $signed(m_axis_tdata[15:0]), 0);
      end else begin
        want = expected_symbols.pop_front();
        if (m_axis_tdata[15:0] !== want.sym_i)
          report_mismatch("symbol_i", $signed(m_axis_tdata[15:0]), want.sym_i);
        if (m_axis_tdata[31:16] !== want.sym_q)
          report_mismatch("symbol_q", $signed(m_axis_tdata[31:16]), want.sym_q);
        if (m_axis_tdata[47:32] !== want.phase)
          report_mismatch("timing_phase", $signed(m_axis_tdata[47:32]), want.phase);
        if (m_axis_tuser !== want.first)
          report_mismatch("first_of_burst", m_axis_tuser, want.first);
      end
    end
    if (stall_req && !stall_done) begin
      stall_cnt++;
      if (stall_cnt >= 600) stall_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic push_sample(logic signed [15:0] si, logic signed [15:0] sq, bit start);
    sample_t it;
    it.si = si;
    it.sq = sq;
    it.start = start;
    pending_samples.insert(pending_samples.size(), it);
    queued_cnt++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      gstr_pkg::CFG_SPS:  cur_sps = value[gstr_pkg::SPS_CFG_W-1:0];
      gstr_pkg::CFG_GAIN: cur_gain = value[gstr_pkg::GAIN_W-1:0];
      gstr_pkg::CFG_OFS:  cur_ofs = value[gstr_pkg::OFS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_timing(int sps, int gain, int ofs);
    logic [15:0] v;
    v = 16'($urandom);
    v[gstr_pkg::SPS_CFG_W-1:0] = gstr_pkg::SPS_CFG_W'(sps);
    write_reg(gstr_pkg::CFG_SPS, v);
    write_reg(gstr_pkg::CFG_GAIN, 16'(gain));
    v = 16'($urandom);
    v[gstr_pkg::OFS_W-1:0] = gstr_pkg::OFS_W'(ofs);
    write_reg(gstr_pkg::CFG_OFS, v);
  endtask

  task automatic settle();
    while (accepted_cnt != queued_cnt || expected_symbols.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic queue_burst(int len, int sps, bit with_start, bit shaped);
    int lvl_i;
    int lvl_q;
    int prv_i;
    int prv_q;
    int pos;
    int ramp;
    int vi;
    int vq;
    bit start;
    ramp = (sps >= 4) ? sps / 2 : 1;
    pos = $urandom_range(0, sps - 1);
    lvl_i = 0;
    lvl_q = 0;
    prv_i = 0;
    prv_q = 0;
    for (int k = 0; k < len; k++) begin
      if (shaped) begin
        if (pos == 0) begin
          prv_i = lvl_i;
          prv_q = lvl_q;
          lvl_i = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(4096, 16384));
          lvl_q = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(4096, 16384));
        end
        vi = prv_i + (lvl_i - prv_i) * ((pos < ramp) ? pos : ramp) / ramp
             + int'($urandom_range(0, 1023)) - 512;
        vq = prv_q + (lvl_q - prv_q) * ((pos < ramp) ? pos : ramp) / ramp
             + int'($urandom_range(0, 1023)) - 512;
        pos = (pos + 1) % sps;
        start = with_start && k == 0;
      end else begin
        vi = int'($signed(16'($urandom)));
        vq = int'($signed(16'($urandom)));
        start = (with_start && k == 0) || $urandom_range(0, 99) < 3;
      end
      push_sample(16'(vi), 16'(vq), start);
    end
  endtask

  initial begin
    #20ms;
    $display("gardner_symbol_timing_recovery_tb: errors");
    $finish;
  end

  initial begin
    int randomized;
    int sps;
    int eff;
    int gain;
    int ofs;
    int nsym;
    for (int k = 0; k < HistDepth; k++) begin
      hist_i[k] = '0;
      hist_q[k] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // state straight out of reset, no burst start yet
    push_sample(16'sh7fff, -16'sh8000, 1'b0);
    push_sample(-16'sh8000, 16'sh7fff, 1'b0);
    push_sample(16'sh0001, -16'sh0001, 1'b0);
    settle();

    // shortest interval, full gain, alternating extremes to drive mu to both clamps
    set_timing(2, 65535, 0);
    push_sample(16'sh7fff, 16'sh7fff, 1'b1);
    for (int k = 0; k < 12; k++)
      push_sample(k[0] ? -16'sh8000 : 16'sh7fff, k[1] ? 16'sh7fff : -16'sh8000, 1'b0);
    settle();

    // interval below range, zero gain, short offset
    set_timing(0, 0, 3);
    push_sample(-16'sh8000, 16'sh0000, 1'b1);
    for (int k = 0; k < 8; k++)
      push_sample(16'(k * 4000), -16'(k * 4000), 1'b0);
    settle();

    randomized = 0;
    for (int ph = 0; randomized < 2000 || ph < 4; ph++) begin
      calm = (ph == 1);
      if (ph == 3) stall_req = 1'b1;
      if (ph == 2) begin
        ofs = $urandom_range(1024, 1200);
        set_timing(2, $urandom_range(0, 4000), ofs);
        queue_burst(ofs + 24, 2, 1'b1, 1'b1);
        randomized += ofs + 24;
        settle();
        continue;
      end
      case ($urandom_range(0, 15))
        0:       sps = $urandom_range(0, 1);
        1:       sps = 80;
        2:       sps = $urandom_range(81, 127);
        3:       sps = $urandom_range(17, 79);
        default: sps = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 7))
        0:       gain = 0;
        1:       gain = 65535;
        2:       gain = $urandom_range(0, 65535);
        default: gain = $urandom_range(0, 4000);
      endcase
      ofs = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 300) : $urandom_range(0, 20);
      eff = (sps < 2) ? 2 : (sps > 80) ? 80 : sps;
      set_timing(sps, gain, ofs);
      for (int b = $urandom_range(1, 3); b > 0; b--) begin
        nsym = (eff > 20) ? $urandom_range(2, 5) : $urandom_range(4, 24);
        queue_burst(ofs + nsym * eff + 2, eff, $urandom_range(0, 4) != 0,
                    $urandom_range(0, 99) < 85);
        randomized += ofs + nsym * eff + 2;
      end
      settle();
    end

    if (expected_symbols.size() != 0)
      report_mismatch("missing symbols", 0, expected_symbols.size());
    if (errors == 0) begin
      $display("gardner_symbol_timing_recovery_tb: clean");
    end else begin
      $display("gardner_symbol_timing_recovery_tb: errors");
    end
    $finish;
  end

endmodule
